// ===== design/whf_pkg.sv =====
// ----------------------------------------------------------------------------
// whf_pkg - shared types and constants for the weighted histogram fill block
// Sequencer states, register map, divider handshake and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package whf_pkg;

	// fixed field widths
	localparam int DVD_W   = 32;  // dividend: sample - low_edge, known non-negative
	localparam int DVS_W   = 31;  // divisor: bin_width
	localparam int TOT_W   = 48;  // bin totals and centers
	localparam int CNT_W   = 11;  // bin_count register
	localparam int IDX_W   = 10;  // bin_index / read_index fields

	localparam logic [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
	localparam logic [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

	// register map, word index
	typedef enum logic [1:0] {
		REG_LOW_EDGE  = 2'd0,
		REG_BIN_WIDTH = 2'd1,
		REG_BIN_COUNT = 2'd2,
		REG_WEIGHTED  = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_UPDATE,
		S_CENTER,
		S_DONE
	} whf_state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} whf_div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} whf_div_sts_t;

endpackage

`default_nettype wire

// ===== design/weighted_histogram_fill_top.sv =====
// ----------------------------------------------------------------------------
// weighted_histogram_fill_top - one-dimensional weighted histogram
// Uniform bins in signed Q16.16; bin search by a shared serial divider,
// totals in a 48-bit saturating store, bin reads with center computation.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | opcode, sample_value, sample_weight,
//           |                       | read_index
//  out      | out_valid / out_ready | bin_index, in_range, bin_center, bin_total
//  cfg      | APB psel/penable      | paddr[3:2] word index, pwdata, prdata
//
//  Accumulate: check, divide (restoring, 32 quotient bits, one per cycle,
//  then done), update, done; past the last bin, no update. Below the first
//  bin or zero width: check, done. Read: check, centre, done; check, done
//  if invalid. After reset a clearing pass writes zero to all MAX_BINS
//  entries, one per cycle; no item is taken meanwhile, config writes are.
//  One item in flight; a finished result sits in the output register, so the
//  next item is taken while it waits, and only the final load stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_histogram_fill_top #(
	parameter int MAX_BINS  = 1024,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	// input items
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                opcode,
	input  wire logic signed [31:0]  sample_value,
	input  wire logic signed [31:0]  sample_weight,
	input  wire logic [9:0]          read_index,

	// result items
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [9:0]               bin_index,
	output logic                     in_range,
	output logic signed [47:0]       bin_center,
	output logic signed [47:0]       bin_total,

	// configuration
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	localparam int AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int TW  = whf_pkg::TOT_W;
	localparam int CW  = whf_pkg::CNT_W;
	localparam int IW  = whf_pkg::IDX_W;
	localparam logic [TW-1:0] UNIT = TW'(1) << FRAC_BITS;  // 1.0 in total units

	// saturate a 49-bit sum into 48 bits
	function automatic logic [TW-1:0] sat48(input logic [TW:0] v);
		logic [TW-1:0] r;
		if (v[TW] != v[TW-1]) begin
			r = v[TW] ? whf_pkg::TOT_MIN : whf_pkg::TOT_MAX;
		end else begin
			r = v[TW-1:0];
		end
		return r;
	endfunction

	// ---------------- configuration registers ----------------
	logic [31:0]    low_edge_q;
	logic [30:0]    bin_width_q;
	logic [CW-1:0]  bin_count_q;
	logic           weighted_q;
	logic           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_edge_q  <= '0;
			bin_width_q <= 31'd65536;
			bin_count_q <= 11'd1024;
			weighted_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (whf_pkg::cfg_reg_t'(paddr[3:2]))
				whf_pkg::REG_LOW_EDGE:  low_edge_q  <= pwdata;
				whf_pkg::REG_BIN_WIDTH: bin_width_q <= pwdata[30:0];
				whf_pkg::REG_BIN_COUNT: bin_count_q <= pwdata[CW-1:0];
				whf_pkg::REG_WEIGHTED:  weighted_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (whf_pkg::cfg_reg_t'(paddr[3:2]))
			whf_pkg::REG_LOW_EDGE:  prdata = low_edge_q;
			whf_pkg::REG_BIN_WIDTH: prdata = {1'b0, bin_width_q};
			whf_pkg::REG_BIN_COUNT: prdata = {21'b0, bin_count_q};
			whf_pkg::REG_WEIGHTED:  prdata = {31'b0, weighted_q};
			default:                prdata = '0;
		endcase
	end

	// bins in use: min(bin_count, MAX_BINS)
	logic [CW-1:0] eff_count;
	assign eff_count = ({21'b0, bin_count_q} < 32'(MAX_BINS)) ? bin_count_q : CW'(MAX_BINS);

	// ---------------- item registers ----------------
	whf_pkg::whf_state_t state_q, state_d;

	logic               op_q;
	logic [31:0]        weight_q;
	logic [IW-1:0]      ridx_q;
	logic [32:0]        diff_q;      // sample - low_edge, 33-bit signed
	logic [AW-1:0]      idx_q;
	logic [41:0]        prod_q;      // (2i+1) * width
	logic [AW-1:0]      clr_q;

	logic [IW-1:0]      res_index_q;
	logic               res_in_range_q;
	logic [TW-1:0]      res_center_q;
	logic [TW-1:0]      res_total_q;

	logic               out_valid_q;
	logic [IW-1:0]      out_index_q;
	logic               out_in_range_q;
	logic [TW-1:0]      out_center_q;
	logic [TW-1:0]      out_total_q;

	// ---------------- shared divider and bin store ----------------
	whf_pkg::whf_div_req_t div_req;
	whf_pkg::whf_div_sts_t div_sts;
	logic [whf_pkg::DVD_W-1:0] quot;
	logic                      div_start;

	whf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.sts      (div_sts),
		.quotient (quot)
	);

	logic           mem_wr_en;
	logic [AW-1:0]  mem_wr_addr;
	logic [TW-1:0]  mem_wr_data;
	logic           mem_rd_en;
	logic [AW-1:0]  mem_rd_addr;
	logic [TW-1:0]  mem_rd_data;

	whf_mem #(
		.DEPTH (MAX_BINS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// ---------------- datapath terms ----------------
	logic           diff_bad;   // below the first bin, or zero width
	logic           ridx_ok;
	logic           quot_ok;
	logic           slot_free;
	logic [TW-1:0]  add_val;
	logic [TW-1:0]  sum_sat;
	logic [TW-1:0]  center_sat;
	logic [41:0]    prod_w;
	logic [CW-1:0]  ridx_odd;

	assign diff_bad  = diff_q[32] || (bin_width_q == '0);
	assign ridx_ok   = ({1'b0, ridx_q} < eff_count);
	assign quot_ok   = (quot < {21'b0, eff_count});
	assign slot_free = !out_valid_q || out_ready;
	assign add_val   = weighted_q ? {{(TW-32){weight_q[31]}}, weight_q} : UNIT;
	assign sum_sat   = sat48({mem_rd_data[TW-1], mem_rd_data} + {add_val[TW-1], add_val});
	// centre = low_edge + floor((2i+1)*width / 2)
	assign center_sat = sat48({{(TW-31){low_edge_q[31]}}, low_edge_q} + {8'b0, prod_q[41:1]});
	assign ridx_odd  = {ridx_q, 1'b1};
	assign prod_w    = 42'(ridx_odd) * 42'(bin_width_q);

	assign div_req.start    = div_start;
	assign div_req.dividend = diff_q[31:0];
	assign div_req.divisor  = bin_width_q;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= whf_pkg::S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == whf_pkg::S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		div_start     = 1'b0;
		mem_wr_en     = 1'b0;
		mem_wr_addr   = idx_q;
		mem_wr_data   = sum_sat;
		mem_rd_en     = 1'b0;
		mem_rd_addr   = AW'(quot);
		unique case (state_q)
			whf_pkg::S_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_q;
				mem_wr_data = '0;
				if (clr_q == AW'(MAX_BINS - 1)) begin
					state_d = whf_pkg::S_IDLE;
				end
			end
			whf_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = whf_pkg::S_CHECK;
				end
			end
			whf_pkg::S_CHECK: begin
				if (op_q) begin
					if (ridx_ok) begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = AW'({22'b0, ridx_q});
						state_d     = whf_pkg::S_CENTER;
					end else begin
						state_d = whf_pkg::S_DONE;
					end
				end else if (diff_bad) begin
					state_d = whf_pkg::S_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = whf_pkg::S_DIV;
				end
			end
			whf_pkg::S_DIV: begin
				if (div_sts.done) begin
					if (quot_ok) begin
						mem_rd_en = 1'b1;
						state_d   = whf_pkg::S_UPDATE;
					end else begin
						state_d = whf_pkg::S_DONE;
					end
				end
			end
			whf_pkg::S_UPDATE: begin
				mem_wr_en = 1'b1;
				state_d   = whf_pkg::S_DONE;
			end
			whf_pkg::S_CENTER: begin
				state_d = whf_pkg::S_DONE;
			end
			whf_pkg::S_DONE: begin
				if (slot_free) begin
					state_d = whf_pkg::S_IDLE;
				end
			end
			default: state_d = whf_pkg::S_IDLE;
		endcase
	end

	assign in_ready = (state_q == whf_pkg::S_IDLE);

	// item and result working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			whf_pkg::S_IDLE: begin
				if (in_valid) begin
					op_q     <= opcode;
					weight_q <= sample_weight;
					ridx_q   <= read_index;
					diff_q   <= {sample_value[31], sample_value} - {low_edge_q[31], low_edge_q};
				end
			end
			whf_pkg::S_CHECK: begin
				// defaults: out-of-range result
				res_index_q    <= op_q ? ridx_q : '0;
				res_in_range_q <= 1'b0;
				res_center_q   <= '0;
				res_total_q    <= '0;
				prod_q         <= prod_w;
			end
			whf_pkg::S_DIV: begin
				if (div_sts.done && quot_ok) begin
					idx_q       <= AW'(quot);
					res_index_q <= quot[IW-1:0];
				end
			end
			whf_pkg::S_UPDATE: begin
				res_in_range_q <= 1'b1;
				res_total_q    <= sum_sat;
			end
			whf_pkg::S_CENTER: begin
				res_in_range_q <= 1'b1;
				res_center_q   <= center_sat;
				res_total_q    <= mem_rd_data;
			end
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == whf_pkg::S_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == whf_pkg::S_DONE && slot_free) begin
			out_index_q    <= res_index_q;
			out_in_range_q <= res_in_range_q;
			out_center_q   <= res_center_q;
			out_total_q    <= res_total_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign bin_index  = out_index_q;
	assign in_range   = out_in_range_q;
	assign bin_center = out_center_q;
	assign bin_total  = out_total_q;

	// ---------------- assertions ----------------
	// one item at a time: an accepted item blocks the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// the divider runs only while the sequencer waits on it
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.busy || div_sts.done |-> state_q == whf_pkg::S_DIV)
		else $error("divider active outside divide state");

	// accumulate updates land in range with no centre
	a_update_res: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == whf_pkg::S_UPDATE |=> res_in_range_q && res_center_q == '0)
		else $error("accumulate result malformed");

	// out-of-range results carry zero centre and total
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> bin_total == '0 && bin_center == '0)
		else $error("out-of-range result not zeroed");

endmodule

`default_nettype wire

// ===== design/whf_div.sv =====
// ----------------------------------------------------------------------------
// whf_div - restoring divider, one quotient bit per cycle
// Unsigned 32 / 31 bit divide; quotient holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module whf_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire whf_pkg::whf_div_req_t        req,
	output whf_pkg::whf_div_sts_t             sts,
	output logic [whf_pkg::DVD_W-1:0]         quotient
);

	localparam int STEP_W = $clog2(whf_pkg::DVD_W);

	logic [whf_pkg::DVD_W-1:0] dq_q;   // dividend bits shift out, quotient bits shift in
	logic [whf_pkg::DVS_W-1:0] rem_q;
	logic [whf_pkg::DVS_W-1:0] dvs_q;
	logic [STEP_W-1:0]         step_q;
	logic                      busy_q;
	logic                      done_q;

	logic [whf_pkg::DVS_W:0]   r_sh;
	logic [whf_pkg::DVS_W:0]   r_sub;
	logic                      ge;

	assign r_sh  = {rem_q, dq_q[whf_pkg::DVD_W-1]};
	assign r_sub = r_sh - {1'b0, dvs_q};
	assign ge    = (r_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(whf_pkg::DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[whf_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? r_sub[whf_pkg::DVS_W-1:0] : r_sh[whf_pkg::DVS_W-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = dq_q;

endmodule

`default_nettype wire

// ===== design/whf_mem.sv =====
// ----------------------------------------------------------------------------
// whf_mem - bin total store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module whf_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [AW-1:0]              wr_addr,
	input  wire logic [whf_pkg::TOT_W-1:0]  wr_data,
	input  wire logic                       rd_en,
	input  wire logic [AW-1:0]              rd_addr,
	output logic [whf_pkg::TOT_W-1:0]       rd_data
);

	logic [whf_pkg::TOT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire
